>>> rtl/core/ramped_position_servo_core_defines.svh
// Assertion macros for the ramped position servo core.
// Included by files that carry concurrent assertions; depends on nothing else.
`ifndef RAMPED_POSITION_SERVO_CORE_DEFINES_SVH
`define RAMPED_POSITION_SERVO_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rps_pkg.sv
// Shared widths, codes and structs for the ramped position servo core.
// Depends on nothing; the interfaces and modules of the core import it.
package rps_pkg;

    localparam int POS_W      = 16;
    localparam int DUTY_W     = 8;
    localparam int RAMP_W     = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int CMP_W      = (DIFF_W > RAMP_W) ? DIFF_W : RAMP_W;
    localparam int PROD_W     = RAMP_W + DUTY_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int STEP_W     = $clog2(PROD_W + 1);
    localparam int OSC_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RAMP_W;

    localparam logic [RAMP_W-1:0] RAMP_RESET     = RAMP_W'(100);
    localparam logic [DUTY_W-1:0] MIN_DUTY_RESET = '0;
    localparam logic [DUTY_W-1:0] MAX_DUTY_RESET = DUTY_W'(255);

    localparam logic [OSC_W-1:0] OSC_LIMIT = OSC_W'(3);
    localparam logic [OSC_W-1:0] OSC_SAT   = OSC_W'(4);

    localparam logic CMD_SET_TARGET = 1'b0;
    localparam logic CMD_SAMPLE     = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_WIDTH = 2'd0,
        CFG_MIN_DUTY   = 2'd1,
        CFG_MAX_DUTY   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [RAMP_W-1:0] ramp_width;
        logic [DUTY_W-1:0] min_duty;
        logic [DUTY_W-1:0] max_duty;
    } cfg_regs_t;

    typedef struct packed {
        logic              start;
        logic [RAMP_W-1:0] err;
        logic [DUTY_W-1:0] span_mag;
        logic [RAMP_W-1:0] ramp;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [DUTY_W-1:0] quotient;
    } md_rsp_t;

endpackage

>>> rtl/core/rps_ifs.sv
// Channel interfaces of the ramped position servo core: sample/command input,
// duty result output and configuration write. Depends on rps_pkg.
interface rps_item_if;
    import rps_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [POS_W-1:0] new_target;
    logic signed [POS_W-1:0] position;
    modport source (output valid, command, new_target, position, input ready);
    modport sink   (input valid, command, new_target, position, output ready);
endinterface

interface rps_result_if;
    import rps_pkg::*;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] drive_a;
    logic [DUTY_W-1:0] drive_b;
    logic              locked_out;
    modport source (output valid, drive_a, drive_b, locked_out, input ready);
    modport sink   (input valid, drive_a, drive_b, locked_out, output ready);
endinterface

interface rps_cfg_if;
    import rps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ramped_position_servo_core.sv
// Top level of the ramped position servo: configuration registers, sequencer
// and shared multiply/divide unit. Depends on rps_pkg, rps_ifs, rps_ctrl,
// rps_muldiv and the assertion macro header.
//
// Proportional position servo with a linear duty ramp and an oscillation
// lockout. A command 0 transaction on item stores new_target, clears the
// direction-change count and gives no result. A command 1 transaction
// (position sample) gives exactly one result transaction: forward duty on
// drive_a when the position is below target, reverse duty on drive_b
// when above, both zero at target. Beyond ramp_width the duty is max_duty;
// inside it is min_duty + (|error| * (max_duty - min_duty)) / ramp_width,
// truncated toward zero. After more than three changes of direction since the
// last target, drive is forced to zero and locked_out is set. A sample that
// is locked out, on target or beyond the ramp goes from S_EVAL straight to
// S_SEND; a sample inside the ramp waits in S_WAIT on the shared adder:
// 8 shift-add multiply steps plus 24 restoring divide steps, one per cycle.
// item.ready is low while a sample is in work. The result sits in an output
// register, so the next item is accepted while a result waits. The cfg port
// is always ready; write registers only while the block is idle.
`include "ramped_position_servo_core_defines.svh"

module ramped_position_servo_core (
    input  logic         clk,
    input  logic         rst_n,
    rps_item_if.sink     item,
    rps_result_if.source result,
    rps_cfg_if.sink      cfg
);
    import rps_pkg::*;

    cfg_regs_t cfg_regs_reg, cfg_regs_next;
    md_req_t   md_req;
    md_rsp_t   md_rsp;

    // Configuration writes; indexes past the register list are dropped.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_regs_next = cfg_regs_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_RAMP_WIDTH: cfg_regs_next.ramp_width = cfg.data[RAMP_W-1:0];
                CFG_MIN_DUTY:   cfg_regs_next.min_duty   = cfg.data[DUTY_W-1:0];
                CFG_MAX_DUTY:   cfg_regs_next.max_duty   = cfg.data[DUTY_W-1:0];
                default:        cfg_regs_next            = cfg_regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.ramp_width <= RAMP_RESET;
            cfg_regs_reg.min_duty   <= MIN_DUTY_RESET;
            cfg_regs_reg.max_duty   <= MAX_DUTY_RESET;
        end
        else
        begin
            cfg_regs_reg <= cfg_regs_next;
        end
    end

    // Sequencer: classifies each sample and owns the output register.
    rps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs_reg),
        .item     (item),
        .result   (result),
        .md_req   (md_req),
        .md_rsp   (md_rsp)
    );

    // Shared unit: ramp duty offset, one adder step per cycle.
    rps_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // Lockout must never leave drive on either wire.
    `RPS_ASSERT_IMPL(a_lockout_zero, clk, rst_n, result.valid && result.locked_out, result.drive_a == '0 && result.drive_b == '0, "lockout result with nonzero drive")
    // Never drive both bridge wires at once.
    `RPS_ASSERT_IMPL(a_one_wire, clk, rst_n, result.valid, result.drive_a == '0 || result.drive_b == '0, "both bridge wires driven")
    // A sample occupies the block: no new item the cycle after it is taken.
    `RPS_ASSERT_NEXT(a_busy_after_sample, clk, rst_n, item.valid && item.ready && item.command == CMD_SAMPLE, !item.ready, "ready high right after a sample")

endmodule

>>> rtl/core/rps_muldiv.sv
// Shared shift-add multiplier and restoring divider: (err * span) / ramp.
// One adder serves both phases. Depends on rps_pkg.
module rps_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  rps_pkg::md_req_t req,
    output rps_pkg::md_rsp_t rsp
);
    import rps_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_DONE} mstate_t;

    mstate_t             state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]   work_reg, work_next;
    logic [RAMP_W-1:0]   rem_reg, rem_next;
    logic [RAMP_W-1:0]   err_reg, err_next;
    logic [DUTY_W-1:0]   span_reg, span_next;
    logic [RAMP_W-1:0]   ramp_reg, ramp_next;

    logic [SUM_W-1:0]    op_a, op_b, sum;
    logic                cin;
    logic [RAMP_W:0]     rem_shift;
    logic                fits;

    // Shared adder: accumulate in multiply phase, trial subtract in divide phase.
    assign rem_shift = {rem_reg, work_reg[PROD_W-1]};

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        cin  = 1'b0;
        case (state_reg)
            M_MUL:
            begin
                op_a = {work_reg, 1'b0};
                op_b = span_reg[DUTY_W-1] ? SUM_W'(err_reg) : '0;
            end
            M_DIV:
            begin
                op_a = SUM_W'(rem_shift);
                op_b = ~SUM_W'(ramp_reg);
                cin  = 1'b1;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
        sum = op_a + op_b + SUM_W'(cin);
    end

    assign fits = ~sum[SUM_W-1];

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        err_next   = err_reg;
        span_next  = span_reg;
        ramp_next  = ramp_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    err_next   = req.err;
                    span_next  = req.span_mag;
                    ramp_next  = req.ramp;
                    work_next  = '0;
                    rem_next   = '0;
                    step_next  = STEP_W'(DUTY_W - 1);
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                work_next = sum[PROD_W-1:0];
                span_next = {span_reg[DUTY_W-2:0], 1'b0};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    step_next  = STEP_W'(PROD_W - 1);
                    state_next = M_DIV;
                end
            end
            M_DIV:
            begin
                // Shift quotient bit in, keep remainder below ramp.
                rem_next  = fits ? sum[RAMP_W-1:0] : rem_shift[RAMP_W-1:0];
                work_next = {work_reg[PROD_W-2:0], fits};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = M_DONE;
                end
            end
            M_DONE:
            begin
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        err_reg  <= err_next;
        span_reg <= span_next;
        ramp_reg <= ramp_next;
    end

    assign rsp.done     = (state_reg == M_DONE);
    assign rsp.quotient = work_reg[DUTY_W-1:0];

endmodule

>>> rtl/core/rps_ctrl.sv
// Servo sequencer: target and oscillation state, error classification,
// ramp request to the shared unit and the output register. Depends on rps_pkg.
module rps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  rps_pkg::cfg_regs_t cfg_regs,
    rps_item_if.sink           item,
    rps_result_if.source       result,
    output rps_pkg::md_req_t   md_req,
    input  rps_pkg::md_rsp_t   md_rsp
);
    import rps_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_WAIT, S_SEND} state_t;

    state_t              state_reg, state_next;
    logic [POS_W-1:0]    target_reg, target_next;
    logic [OSC_W-1:0]    osc_reg, osc_next;
    logic                last_below_reg, last_below_next;
    logic [DIFF_W-1:0]   diff_reg, diff_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic                fwd_reg, fwd_next;
    logic                locked_reg, locked_next;
    logic                span_neg_reg, span_neg_next;
    logic                out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]   drive_a_reg, drive_a_next;
    logic [DUTY_W-1:0]   drive_b_reg, drive_b_next;
    logic                locked_out_reg, locked_out_next;

    logic                accept;
    logic [DIFF_W-1:0]   diff;
    logic                below;
    logic [DIFF_W-1:0]   mag;
    logic                beyond;
    logic                span_neg;
    logic [DUTY_W-1:0]   span_mag;
    logic                ramp_go;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid & item.ready;

    // target - position, sign extended by one bit
    assign diff  = {target_reg[POS_W-1], target_reg}
                 - {item.position[POS_W-1], item.position};
    assign below = ~diff[DIFF_W-1] & (diff != '0);

    assign mag      = diff_reg[DIFF_W-1] ? (DIFF_W'(0) - diff_reg) : diff_reg;
    assign beyond   = CMP_W'(mag) > CMP_W'(cfg_regs.ramp_width);
    assign span_neg = cfg_regs.max_duty < cfg_regs.min_duty;
    assign span_mag = span_neg ? (cfg_regs.min_duty - cfg_regs.max_duty)
                               : (cfg_regs.max_duty - cfg_regs.min_duty);
    assign ramp_go  = (state_reg == S_EVAL) & (osc_reg <= OSC_LIMIT)
                    & (mag != '0) & ~beyond;

    assign md_req.start    = ramp_go;
    assign md_req.err      = RAMP_W'(mag);
    assign md_req.span_mag = span_mag;
    assign md_req.ramp     = cfg_regs.ramp_width;

    always_comb
    begin
        state_next      = state_reg;
        target_next     = target_reg;
        osc_next        = osc_reg;
        last_below_next = last_below_reg;
        diff_next       = diff_reg;
        duty_next       = duty_reg;
        fwd_next        = fwd_reg;
        locked_next     = locked_reg;
        span_neg_next   = span_neg_reg;
        out_valid_next  = out_valid_reg;
        drive_a_next    = drive_a_reg;
        drive_b_next    = drive_b_reg;
        locked_out_next = locked_out_reg;

        // drop the output transaction once taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == CMD_SET_TARGET)
                    begin
                        target_next     = item.new_target;
                        osc_next        = '0;
                        last_below_next = 1'b0;
                    end
                    else
                    begin
                        if ((below != last_below_reg) && (osc_reg != OSC_SAT))
                        begin
                            osc_next = osc_reg + OSC_W'(1);
                        end
                        last_below_next = below;
                        diff_next       = diff;
                        state_next      = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                fwd_next      = ~diff_reg[DIFF_W-1];
                locked_next   = (osc_reg > OSC_LIMIT);
                span_neg_next = span_neg;
                duty_next     = '0;
                if (osc_reg > OSC_LIMIT || mag == '0)
                begin
                    state_next = S_SEND;
                end
                else if (beyond)
                begin
                    duty_next  = cfg_regs.max_duty;
                    state_next = S_SEND;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (md_rsp.done)
                begin
                    duty_next  = span_neg_reg ? (cfg_regs.min_duty - md_rsp.quotient)
                                              : (cfg_regs.min_duty + md_rsp.quotient);
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    drive_a_next    = fwd_reg ? duty_reg : '0;
                    drive_b_next    = fwd_reg ? '0 : duty_reg;
                    locked_out_next = locked_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            target_reg     <= '0;
            osc_reg        <= '0;
            last_below_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            target_reg     <= target_next;
            osc_reg        <= osc_next;
            last_below_reg <= last_below_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg       <= diff_next;
        duty_reg       <= duty_next;
        fwd_reg        <= fwd_next;
        locked_reg     <= locked_next;
        span_neg_reg   <= span_neg_next;
        drive_a_reg    <= drive_a_next;
        drive_b_reg    <= drive_b_next;
        locked_out_reg <= locked_out_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.drive_a    = drive_a_reg;
    assign result.drive_b    = drive_b_reg;
    assign result.locked_out = locked_out_reg;

endmodule
